@@ rtl/core/tmed_pkg.sv @@
// Shared types and constants of the two-mode echo delay line.
// No dependencies; imported by every module of the block except tmed_ram.
package tmed_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int QUEUE_DEPTH = 4;

   // register indexes (csr byte address bits [3:2])
   localparam logic [1:0] REG_DELAY_BLOCKS  = 2'd0;
   localparam logic [1:0] REG_FEEDBACK_MODE = 2'd1;
   localparam logic [1:0] REG_BLOCK_LENGTH  = 2'd2;

   typedef struct packed {
      logic feedback;    // 1: feedback echo, 0: plain two-tap
      logic zero_delay;  // clamped delay is zero entries
   } cfg_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       self_mix; // plain mode, zero delay: mix with itself
   } item_type;

endpackage

@@ rtl/core/two_mode_echo_delay_line_core.sv @@
// Top level of the two-mode echo delay line: register file, front end, queue, back end.
// Depends on tmed_pkg, tmed_front, tmed_queue, tmed_back and tmed_ram.
//
// Stereo-interleaved Q1.15 echo: one sample word in and one out per clock cycle,
// sustained while rsp_tready stays high, set by the single write port and single
// read port of the delay store RAM. A word reaches rsp through the input register,
// queue, store read stage and response register. Delay is delay_blocks *
// block_length * CHANNELS entries, clamped to STORE_DEPTH-1, and is updated at
// the same edge as the register write. The store needs no clearing pass: entries
// not yet written since reset read as zero by tracking the write pointer.
module two_mode_echo_delay_line_core
   import tmed_pkg::*;
#(
   parameter int STORE_DEPTH = 262144,
   parameter int CHANNELS    = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [SAMPLE_W-1:0] req_tdata,   // [15:0] in_sample
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [SAMPLE_W-1:0] rsp_tdata,   // [15:0] out_sample
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [3:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready
);

   localparam int ADDR_W = $clog2(STORE_DEPTH);
   localparam int PROD_W = 21 + $clog2(CHANNELS + 1);
   localparam logic [PROD_W-1:0] LIMIT = PROD_W'(STORE_DEPTH - 1);

   logic [7:0]        delay_blocks_ff, delay_blocks_in;
   logic              feedback_mode_ff, feedback_mode_in;
   logic [12:0]       block_length_ff, block_length_in;
   logic [ADDR_W-1:0] delay_ff, delay_in;
   logic [PROD_W-1:0] prod;
   logic              wr;
   cfg_type           cfg;

   logic     f_valid, f_ready, q_valid, q_ready;
   item_type f_item, q_item;

   assign csr_pready = 1'b1;
   assign wr = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      delay_blocks_in  = delay_blocks_ff;
      feedback_mode_in = feedback_mode_ff;
      block_length_in  = block_length_ff;
      if (wr) begin
         unique case (csr_paddr[3:2])
            REG_DELAY_BLOCKS:  delay_blocks_in  = csr_pwdata[7:0];
            REG_FEEDBACK_MODE: feedback_mode_in = csr_pwdata[0];
            REG_BLOCK_LENGTH:  block_length_in  = csr_pwdata[12:0];
            default: ;
         endcase
      end
   end

   // delay follows the new register values in the same edge
   assign prod     = PROD_W'(delay_blocks_in) * PROD_W'(block_length_in) * PROD_W'(CHANNELS);
   assign delay_in = (prod > LIMIT) ? ADDR_W'(STORE_DEPTH - 1) : prod[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_blocks_ff  <= '0;
         feedback_mode_ff <= 1'b1;
         block_length_ff  <= 13'd1024;
         delay_ff         <= '0;
      end else begin
         delay_blocks_ff  <= delay_blocks_in;
         feedback_mode_ff <= feedback_mode_in;
         block_length_ff  <= block_length_in;
         delay_ff         <= delay_in;
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_DELAY_BLOCKS:  csr_prdata = {24'd0, delay_blocks_ff};
         REG_FEEDBACK_MODE: csr_prdata = {31'd0, feedback_mode_ff};
         REG_BLOCK_LENGTH:  csr_prdata = {19'd0, block_length_ff};
         default:           csr_prdata = '0;
      endcase
   end

   assign cfg.feedback   = feedback_mode_ff;
   assign cfg.zero_delay = delay_ff == '0;

   tmed_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .f_valid    (f_valid),
      .f_ready    (f_ready),
      .f_item     (f_item)
   );

   tmed_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_item  (f_item),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_item   (q_item)
   );

   tmed_back #(
      .STORE_DEPTH (STORE_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .delay      (delay_ff),
      .q_valid    (q_valid),
      .q_ready    (q_ready),
      .q_item     (q_item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

@@ rtl/core/tmed_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module tmed_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/tmed_front.sv @@
// Front end: takes request words into an input register and tags each one.
// Depends on tmed_pkg.
module tmed_front
   import tmed_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [SAMPLE_W-1:0] req_tdata,
   output logic                f_valid,
   input  logic                f_ready,
   output item_type            f_item
);

   logic     valid_ff, valid_in;
   item_type item_ff;
   logic     take;

   assign req_tready = !valid_ff || f_ready;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (f_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.sample   <= req_tdata;
         item_ff.self_mix <= !cfg.feedback && cfg.zero_delay;
      end
   end

   assign f_valid = valid_ff;
   assign f_item  = item_ff;

endmodule

@@ rtl/core/tmed_queue.sv @@
// Short word queue between front end and back end.
// Depends on tmed_pkg.
module tmed_queue
   import tmed_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  item_type push_item,
   output logic     pop_valid,
   input  logic     pop_ready,
   output item_type pop_item
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type           slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push, pop;

   assign push_ready = count_ff != CNT_W'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_item   = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ rtl/core/tmed_back.sv @@
// Back end: delay store access, mixing and the response register.
// Depends on tmed_pkg and tmed_ram.
module tmed_back
   import tmed_pkg::*;
#(
   parameter int STORE_DEPTH = 262144
) (
   input  logic                             clock,
   input  logic                             reset,
   input  cfg_type                          cfg,
   input  logic [$clog2(STORE_DEPTH)-1:0]   delay,
   input  logic                             q_valid,
   output logic                             q_ready,
   input  item_type                         q_item,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [SAMPLE_W-1:0]              rsp_tdata
);

   localparam int ADDR_W = $clog2(STORE_DEPTH);
   localparam logic [ADDR_W-1:0] LAST    = ADDR_W'(STORE_DEPTH - 1);
   localparam logic [ADDR_W:0]   DEPTH_V = (ADDR_W + 1)'(STORE_DEPTH);

   // write pointer and wrap flag stand in for clearing the store
   logic [ADDR_W-1:0] wp_ff;
   logic              full_ff;

   // read stage
   logic                       p_valid_ff;
   logic signed [SAMPLE_W-1:0] p_x_ff;
   logic                       p_self_ff, p_byp_ff, p_blank_ff;
   logic [ADDR_W-1:0]          p_wa_ff;

   // response stage
   logic                       o_valid_ff;
   logic [SAMPLE_W-1:0]        o_data_ff;
   logic signed [SAMPLE_W-1:0] byp_ff;

   logic                       issue, p_adv, full_eff, blank;
   logic [ADDR_W-1:0]          next_a, base, rd_addr;
   logic [ADDR_W:0]            back_sum;
   logic [SAMPLE_W-1:0]        ram_rd;
   logic signed [SAMPLE_W-1:0] other;
   logic signed [SAMPLE_W:0]   mix_sum;
   logic signed [SAMPLE_W-1:0] y;
   logic                       ram_we;
   logic [ADDR_W-1:0]          ram_wa;
   logic [SAMPLE_W-1:0]        ram_wd;

   assign p_adv   = p_valid_ff && (!o_valid_ff || rsp_tready);
   assign issue   = q_valid && (!p_valid_ff || p_adv);
   assign q_ready = !p_valid_ff || p_adv;

   assign next_a   = (wp_ff == LAST) ? '0 : wp_ff + 1'b1;
   assign base     = cfg.feedback ? wp_ff : next_a;
   // base >= delay gives the plain difference, else wraps by one depth
   assign back_sum = (base >= delay) ? ({1'b0, base} - {1'b0, delay})
                                     : ({1'b0, base} + DEPTH_V - {1'b0, delay});
   assign rd_addr  = back_sum[ADDR_W-1:0];
   // plain mode writes entry zero in this cycle when the pointer wraps
   assign full_eff = full_ff || (!cfg.feedback && next_a == '0);
   assign blank    = !(full_eff || (rd_addr != '0 && rd_addr <= base));

   always_comb begin
      if (p_self_ff) begin
         other = p_x_ff;
      end else if (p_byp_ff) begin
         other = byp_ff;
      end else if (p_blank_ff) begin
         other = '0;
      end else begin
         other = signed'(ram_rd);
      end
   end

   assign mix_sum = {p_x_ff[SAMPLE_W-1], p_x_ff} + {other[SAMPLE_W-1], other};
   assign y       = mix_sum[SAMPLE_W:1];   // floor of the mean

   assign ram_we = cfg.feedback ? p_adv : issue;
   assign ram_wa = cfg.feedback ? p_wa_ff : next_a;
   assign ram_wd = cfg.feedback ? y : q_item.sample;

   tmed_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_en   (issue),
      .rd_addr (rd_addr),
      .rd_data (ram_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff      <= '0;
         full_ff    <= 1'b0;
         p_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         if (issue) begin
            wp_ff <= next_a;
            if (next_a == '0) begin
               full_ff <= 1'b1;
            end
         end
         if (issue) begin
            p_valid_ff <= 1'b1;
         end else if (p_adv) begin
            p_valid_ff <= 1'b0;
         end
         if (p_adv) begin
            o_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            o_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         p_x_ff     <= q_item.sample;
         p_self_ff  <= q_item.self_mix;
         // feedback, zero delay: the entry is being written by the word ahead
         p_byp_ff   <= cfg.feedback && cfg.zero_delay && p_adv;
         p_blank_ff <= blank;
         p_wa_ff    <= next_a;
      end
      if (p_adv) begin
         o_data_ff <= y;
         byp_ff    <= y;
      end
   end

   assign rsp_tvalid = o_valid_ff;
   assign rsp_tdata  = o_data_ff;

endmodule

@@ rtl/core/tmed_checker.sv @@
// Port-level checks on the echo delay line core, bound to the top level.
// Depends on tmed_pkg and two_mode_echo_delay_line_core.
module tmed_checker
   import tmed_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_tvalid,
   input logic                req_tready,
   input logic                rsp_tvalid,
   input logic                rsp_tready,
   input logic [SAMPLE_W-1:0] rsp_tdata,
   input logic                csr_psel,
   input logic                csr_pready
);

   // words in flight: input register, queue, read stage, response register
   localparam int CAPACITY = QUEUE_DEPTH + 3;

   logic [3:0] inflight_ff;
   logic       req_take, rsp_take;

   assign req_take = req_tvalid && req_tready;
   assign rsp_take = rsp_tvalid && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else if (req_take && !rsp_take) begin
         inflight_ff <= inflight_ff + 1'b1;
      end else if (rsp_take && !req_take) begin
         inflight_ff <= inflight_ff - 1'b1;
      end
   end

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid straight after reset");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> inflight_ff != '0)
      else $error("response word with no request word outstanding");

   a_bounded: assert property (@(posedge clock) disable iff (reset)
      inflight_ff <= 4'(CAPACITY))
      else $error("more words in flight than the pipeline holds");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response word changed");

   a_pready: assert property (@(posedge clock) disable iff (reset)
      csr_psel |-> csr_pready)
      else $error("register port not ready");

endmodule

bind two_mode_echo_delay_line_core tmed_checker u_tmed_checker (
   .clock       (clock),
   .reset       (reset),
   .req_tvalid  (req_tvalid),
   .req_tready  (req_tready),
   .rsp_tvalid  (rsp_tvalid),
   .rsp_tready  (rsp_tready),
   .rsp_tdata   (rsp_tdata),
   .csr_psel    (csr_psel),
   .csr_pready  (csr_pready)
);
